// File: sv/csep_pkg.sv
package csep_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAX_POINTS = 256;
	localparam int MEM_DEPTH  = 4 * MAX_POINTS;
	localparam int MEM_AW     = $clog2(MEM_DEPTH);
	localparam int CELL_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int SPAN_W     = 32;
	localparam int D_W        = 33;
	localparam int ACC_W      = 38;
	localparam int U_W        = FRAC_BITS + 1;
	localparam int CLAMP_EXP  = 40;
	localparam int MAG_W      = CLAMP_EXP + 1;
	localparam int SAT_W      = MAG_W + 1;
	localparam int DIV_W      = MAG_W + CNT_W + FRAC_BITS + 1;
	localparam int QDEPTH     = 4;
	localparam int QAW        = $clog2(QDEPTH);
	localparam int APB_AW     = 4;

	localparam logic [1:0] REG_BC_MODE  = 2'd0;
	localparam logic [1:0] REG_N_POINTS = 2'd1;
	localparam logic [1:0] REG_X_MIN    = 2'd2;
	localparam logic [1:0] REG_X_MAX    = 2'd3;

	typedef struct packed {
		logic               bc_mode;
		logic [8:0]         n_points;
		logic signed [31:0] x_min;
		logic signed [31:0] x_max;
	} cfg_t;

	// axis geometry derived from the registers
	typedef struct packed {
		logic              periodic;
		logic              span_ok;
		logic [SPAN_W-1:0] span;
		logic [CNT_W-1:0]  cells;
	} geom_t;

	typedef enum logic [1:0] {
		K_WRITE,
		K_EVAL,
		K_REJECT
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [9:0]            addr;
		logic [31:0]           wdata;
		logic signed [D_W-1:0] d;
	} item_t;

	function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic [31:0] r;
		if (v > $signed(SAT_W'(32'h7fff_ffff)))
			r = 32'h7fff_ffff;
		else if (v < -$signed(SAT_W'(33'h0_8000_0000)))
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// File: sv/csep_div.sv
module csep_div
	import csep_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [DIV_W-1:0]  num,
	input  logic [SPAN_W-1:0] den,
	output logic              done,
	output logic [DIV_W-1:0]  quot,
	output logic [SPAN_W-1:0] rem
);

	localparam int DC_W = $clog2(DIV_W);

	logic              busy_q;
	logic [DC_W-1:0]   cnt_q;
	logic [DIV_W-1:0]  sh_q;
	logic [SPAN_W-1:0] rem_q;
	logic [SPAN_W-1:0] den_q;
	logic              done_q;
	logic [SPAN_W:0]   trial;
	logic              qbit;

	// restoring division, one quotient bit a cycle
	always_comb begin
		trial = {rem_q, sh_q[DIV_W-1]};
		qbit  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				sh_q   <= num;
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				sh_q  <= {sh_q[DIV_W-2:0], qbit};
				rem_q <= qbit ? SPAN_W'(trial - {1'b0, den_q}) : trial[SPAN_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DC_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = sh_q;
	assign rem  = rem_q;

endmodule

// File: sv/csep_regs.sv
module csep_regs
	import csep_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg,
	output geom_t             geom
);

	cfg_t              cfg_q;
	logic              wr;
	logic signed [32:0] span_full;
	logic [31:0]       pts;

	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bc_mode  <= 1'b0;
			cfg_q.n_points <= 9'd2;
			cfg_q.x_min    <= '0;
			cfg_q.x_max    <= 32'(1) << FRAC_BITS;
		end else if (wr) begin
			case (paddr[3:2])
				REG_BC_MODE:  cfg_q.bc_mode  <= pwdata[0];
				REG_N_POINTS: cfg_q.n_points <= pwdata[8:0];
				REG_X_MIN:    cfg_q.x_min    <= pwdata;
				REG_X_MAX:    cfg_q.x_max    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BC_MODE:  prdata = {31'b0, cfg_q.bc_mode};
			REG_N_POINTS: prdata = {23'b0, cfg_q.n_points};
			REG_X_MIN:    prdata = cfg_q.x_min;
			REG_X_MAX:    prdata = cfg_q.x_max;
			default:      prdata = '0;
		endcase
	end

	// point count clamped to the table size
	always_comb begin
		pts = {23'b0, cfg_q.n_points};
		if (pts < 32'd2)
			pts = 32'd2;
		else if (pts > 32'(MAX_POINTS))
			pts = 32'(MAX_POINTS);
		span_full     = {cfg_q.x_max[31], cfg_q.x_max} - {cfg_q.x_min[31], cfg_q.x_min};
		geom.periodic = cfg_q.bc_mode;
		geom.span_ok  = !span_full[32] && (span_full != 33'sd0);
		geom.span     = span_full[31:0];
		geom.cells    = cfg_q.bc_mode ? CNT_W'(pts) : CNT_W'(pts - 32'd1);
	end

	assign cfg = cfg_q;

endmodule

// File: sv/csep_front.sv
module csep_front
	import csep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [9:0]  coef_index,
	input  logic [31:0] coef_value,
	input  logic [31:0] x,
	input  cfg_t        cfg,
	input  geom_t       geom,
	input  logic        pop,
	output logic        q_valid,
	output item_t       q_item
);

	item_t          q_mem [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           push;
	item_t          cls;
	logic signed [D_W-1:0] d;
	logic           reject;

	// classify: range and degenerate axis are settled here
	always_comb begin
		d      = {x[31], x} - {cfg.x_min[31], cfg.x_min};
		reject = !geom.span_ok ||
			(!geom.periodic && (d[D_W-1] || ($signed({1'b0, d}) > $signed({2'b0, geom.span}))));
		cls.addr  = coef_index;
		cls.wdata = coef_value;
		cls.d     = d;
		if (!cmd)
			cls.kind = K_WRITE;
		else if (reject)
			cls.kind = K_REJECT;
		else
			cls.kind = K_EVAL;
	end

	assign busy    = count_q == (QAW+1)'(QDEPTH);
	assign push    = start && !busy;
	assign q_valid = count_q != '0;
	assign q_item  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: sv/csep_back.sv
module csep_back
	import csep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  geom_t       geom,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        pop,
	output logic        done,
	output logic [31:0] value,
	output logic [31:0] slope,
	output logic [31:0] curvature,
	output logic        out_of_range
);

	localparam int PROD_W = ACC_W + U_W + 1;
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [MAG_W-1:0] CLAMP = MAG_W'(1) << CLAMP_EXP;

	typedef enum logic [3:0] {
		S_IDLE, S_WRAP, S_CMUL, S_CDIV, S_FETCH, S_MUL, S_ACC, S_SCALE, S_SDIV
	} state_t;

	state_t state_q;

	logic [31:0]        mem [MEM_DEPTH];
	logic [31:0]        rdata_q;
	logic [MEM_AW-1:0]  rd_addr;
	logic               we;

	logic signed [D_W-1:0]   d_q;
	logic [SPAN_W-1:0]       dmod_q;
	logic [CELL_W-1:0]       cell_q;
	logic [U_W-1:0]          u_q;
	logic [2:0]              cnt_q;
	logic [2:0]              step_q;
	logic [1:0]              sel_q;
	logic                    neg_q;
	logic [31:0]             c_q [4];
	logic signed [ACC_W-1:0] f_q, d1_q, d2_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SAT_W-1:0] t_q;
	logic [31:0]             slope_q;

	logic               div_go_q;
	logic [DIV_W-1:0]   div_num_q;
	logic               div_done;
	logic [DIV_W-1:0]   div_quot;
	logic [SPAN_W-1:0]  div_rem;

	logic               done_q, oor_q;
	logic [31:0]        value_q, curv_q;

	logic signed [ACC_W-1:0]  c0e, c1e, c2e, c3e, mop_a, addend, acc_new;
	logic signed [PROD_W-1:0] prod_c, rsum;
	logic signed [SAT_W-1:0]  t_in, sres;
	logic [MAG_W-1:0]         mag, res;
	logic [MAG_W+CNT_W-1:0]   smul;
	logic [SPAN_W+CNT_W-1:0]  cmul;
	logic [DIV_W-FRAC_BITS-1:0] cq;
	logic [DIV_W:0]           rp1;
	logic [DIV_W-1:0]         r1;

	csep_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go_q),
		.num    (div_num_q),
		.den    (geom.span),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	assign pop     = (state_q == S_IDLE) && q_valid;
	assign we      = pop && (q_item.kind == K_WRITE) && (32'(q_item.addr) < 32'(MEM_DEPTH));
	assign rd_addr = {cell_q, cnt_q[1:0]};

	always_ff @(posedge clk) begin
		if (we)
			mem[MEM_AW'(q_item.addr)] <= q_item.wdata;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
	end

	always_comb begin
		c0e = ACC_W'($signed(c_q[0]));
		c1e = ACC_W'($signed(c_q[1]));
		c2e = ACC_W'($signed(c_q[2]));
		c3e = ACC_W'($signed(c_q[3]));
		case (step_q)
			3'd0: begin mop_a = c3e;                   addend = c2e;       end
			3'd1: begin mop_a = f_q;                   addend = c1e;       end
			3'd2: begin mop_a = f_q;                   addend = c0e;       end
			3'd3: begin mop_a = c3e + (c3e <<< 1);     addend = c2e <<< 1; end
			3'd4: begin mop_a = d1_q;                  addend = c1e;       end
			3'd5: begin mop_a = (c3e <<< 2) + (c3e <<< 1); addend = c2e <<< 1; end
			default: begin mop_a = '0;                 addend = '0;        end
		endcase
		prod_c  = mop_a * $signed({1'b0, u_q});
		// floor shift gives nearest, ties upward
		rsum    = (prod_q + HALF) >>> FRAC_BITS;
		acc_new = addend + rsum[ACC_W-1:0];

		case (sel_q)
			2'd0:    t_in = SAT_W'(d1_q);
			2'd1:    t_in = SAT_W'(d2_q);
			default: t_in = t_q;
		endcase
		mag  = t_in[SAT_W-1] ? MAG_W'(-t_in) : MAG_W'(t_in);
		smul = mag * geom.cells;
		cmul = dmod_q * geom.cells;
		cq   = div_quot[DIV_W-1:FRAC_BITS];

		rp1  = {1'b0, div_quot} + (DIV_W+1)'(1);
		r1   = rp1[DIV_W:1];
		res  = (r1 > DIV_W'(CLAMP)) ? CLAMP : r1[MAG_W-1:0];
		sres = neg_q ? -$signed({1'b0, res}) : $signed({1'b0, res});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			cnt_q    <= '0;
			step_q   <= '0;
			sel_q    <= '0;
		end else begin
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						d_q <= q_item.d;
						case (q_item.kind)
							K_REJECT: begin
								done_q    <= 1'b1;
								oor_q     <= 1'b1;
								value_q   <= '0;
								slope_q   <= '0;
								curv_q    <= '0;
							end
							K_EVAL: begin
								if (geom.periodic) begin
									div_num_q <= DIV_W'(q_item.d[D_W-1] ?
										D_W'(-q_item.d) : D_W'(q_item.d));
									div_go_q  <= 1'b1;
									state_q   <= S_WRAP;
								end else begin
									dmod_q  <= q_item.d[SPAN_W-1:0];
									state_q <= S_CMUL;
								end
							end
							default: ;
						endcase
					end
				end
				S_WRAP: begin
					if (div_done) begin
						dmod_q  <= (d_q[D_W-1] && div_rem != '0) ?
							geom.span - div_rem : div_rem;
						state_q <= S_CMUL;
					end
				end
				S_CMUL: begin
					div_num_q <= DIV_W'({cmul, FRAC_BITS'(0)});
					div_go_q  <= 1'b1;
					state_q   <= S_CDIV;
				end
				S_CDIV: begin
					if (div_done) begin
						// top end of the axis lands on the last cell at fraction one
						if (cq >= (DIV_W-FRAC_BITS)'(geom.cells)) begin
							cell_q <= CELL_W'(geom.cells - 1'b1);
							u_q    <= U_W'(1) << FRAC_BITS;
						end else begin
							cell_q <= CELL_W'(cq);
							u_q    <= {1'b0, div_quot[FRAC_BITS-1:0]};
						end
						cnt_q   <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (cnt_q != 3'd0)
						c_q[cnt_q[1:0] - 2'd1] <= rdata_q;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd4) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= prod_c;
					state_q <= S_ACC;
				end
				S_ACC: begin
					case (step_q)
						3'd0, 3'd1, 3'd2: f_q  <= acc_new;
						3'd3, 3'd4:       d1_q <= acc_new;
						default:          d2_q <= acc_new;
					endcase
					step_q <= step_q + 1'b1;
					if (step_q == 3'd5) begin
						sel_q   <= '0;
						state_q <= S_SCALE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_SCALE: begin
					neg_q     <= t_in[SAT_W-1];
					div_num_q <= {smul, (FRAC_BITS+1)'(0)};
					div_go_q  <= 1'b1;
					state_q   <= S_SDIV;
				end
				S_SDIV: begin
					if (div_done) begin
						case (sel_q)
							2'd0: begin
								slope_q <= sat32(sres);
								sel_q   <= 2'd1;
								state_q <= S_SCALE;
							end
							2'd1: begin
								t_q     <= sres;
								sel_q   <= 2'd2;
								state_q <= S_SCALE;
							end
							default: begin
								curv_q  <= sat32(sres);
								value_q <= sat32(SAT_W'(f_q));
								oor_q   <= 1'b0;
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done         = done_q;
	assign value        = value_q;
	assign slope        = slope_q;
	assign curvature    = curv_q;
	assign out_of_range = oor_q;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && oor_q |-> value_q == '0 && slope_q == '0 && curv_q == '0)
		else $error("rejected item carries non-zero results");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_WRAP || state_q == S_CDIV || state_q == S_SDIV)
		else $error("divider finished with no waiting step");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> u_q <= (U_W'(1) << FRAC_BITS))
		else $error("cell fraction above one");

	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_item.kind == K_REJECT |=> done_q && oor_q)
		else $error("rejected item gave no result");

endmodule

// File: sv/cubic_spline_eval_with_derivatives.sv
// Cubic spline evaluator with value, slope and curvature outputs. Items are
// taken on start while busy is low into a four-deep queue; busy rises only
// when that queue is full. A coefficient write goes into the table as it is
// popped. An evaluation runs through a shared one-bit-per-cycle divider: a
// natural-mode item needs four divisions, a periodic one five (the wrap). Each
// division holds the back end for its DIV_W = 67 quotient bits; beside the
// dispatch, the table reads and the Horner steps, the divider sets the rate
// (the wrap division is launched from the dispatch state). A rejected
// coordinate (outside the axis in natural mode, or an empty axis) retires
// straight from idle with zero results and out_of_range set.
// Each result is presented for exactly one cycle with done high; the receiver
// cannot stall, so it must take every transfer as it appears. Results come
// back in the order items were taken. Configuration is written over APB
// (pready always high) and must only change while the block is idle.
module cubic_spline_eval_with_derivatives
	import csep_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  logic              cmd,
	input  logic [9:0]        coef_index,
	input  logic [31:0]       coef_value,
	input  logic [31:0]       x,
	// result channel
	output logic              done,
	output logic [31:0]       value,
	output logic [31:0]       slope,
	output logic [31:0]       curvature,
	output logic              out_of_range,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t  cfg;
	geom_t geom;
	logic  q_valid;
	logic  pop;
	item_t q_item;

	// registers; geometry (span, cell count) is derived here
	csep_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.geom    (geom)
	);

	// front: takes each transfer, range-checks it and queues it
	csep_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.x          (x),
		.cfg        (cfg),
		.geom       (geom),
		.pop        (pop),
		.q_valid    (q_valid),
		.q_item     (q_item)
	);

	// back: coefficient table, locate, Horner and grid scaling
	csep_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.geom         (geom),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.done         (done),
		.value        (value),
		.slope        (slope),
		.curvature    (curvature),
		.out_of_range (out_of_range)
	);

endmodule
